FILE: hw/rtl/tbc_pkg.sv
// Shared types, constants and helper functions of the tilt balance controller.
// Used by tilt_balance_cascade_controller_core; depends on nothing.
package tbc_pkg;

    localparam int STATE_W      = 32;   // Q8.24 state word
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int CNT_W        = 5;
    localparam int MA_W         = 34;   // multiplier A operand
    localparam int MB_W         = 26;   // multiplier B operand
    localparam int P_W          = MA_W + MB_W;
    localparam int Z_W          = 28;   // CORDIC angle accumulator
    localparam int XY_W         = 33;   // CORDIC vector components

    localparam logic signed [MB_W-1:0] K_LEAD_NUM_NEG = -26'sd17448305;
    localparam logic signed [MB_W-1:0] K_LEAD_OLD     = 26'sd16106127;
    localparam logic signed [MB_W-1:0] K_D2_A1        = 26'sd20333986;
    localparam logic signed [MB_W-1:0] K_D2_A2        = 26'sd6001210;
    localparam logic signed [MB_W-1:0] K_D2_B         = 26'sd269442;
    localparam logic signed [MB_W-1:0] K_GYRO         = 26'sd11993811;
    localparam logic signed [Z_W-1:0]  HALF_PI        = 28'sd26353589;

    // configuration register indexes
    localparam logic [2:0] CFG_FILTER_GAIN     = 3'd0;
    localparam logic [2:0] CFG_INNER_GAIN      = 3'd1;
    localparam logic [2:0] CFG_OUTER_GAIN      = 3'd2;
    localparam logic [2:0] CFG_TILT_LIMIT      = 3'd3;
    localparam logic [2:0] CFG_BALANCE_OFFSET  = 3'd4;
    localparam logic [2:0] CFG_REFERENCE_SCALE = 3'd5;
    localparam logic [2:0] CFG_COUNTS_TO_RAD   = 3'd6;

    localparam logic CMD_IMU = 1'b0;
    localparam logic CMD_ENC = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CORDIC, ST_MUL, ST_WB, ST_FINISH
    } state_t;

    // multiply steps, run in this order
    typedef enum logic [3:0] {
        OP_AFILT, OP_GYRO, OP_HPF, OP_REF, OP_LEAD, OP_LAG, OP_DUTY,
        OP_LEFT, OP_RIGHT, OP_PHI, OP_PHI2, OP_A1, OP_A2, OP_DRIVE
    } op_t;

    function automatic logic signed [Z_W-1:0] atan_lut(input logic [CNT_W-1:0] i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            5'd0:  v = 28'sd13176795;
            5'd1:  v = 28'sd7778716;
            5'd2:  v = 28'sd4110060;
            5'd3:  v = 28'sd2086331;
            5'd4:  v = 28'sd1047214;
            5'd5:  v = 28'sd524117;
            5'd6:  v = 28'sd262123;
            5'd7:  v = 28'sd131069;
            5'd8:  v = 28'sd65536;
            5'd9:  v = 28'sd32768;
            5'd10: v = 28'sd16384;
            5'd11: v = 28'sd8192;
            5'd12: v = 28'sd4096;
            5'd13: v = 28'sd2048;
            5'd14: v = 28'sd1024;
            5'd15: v = 28'sd512;
            5'd16: v = 28'sd256;
            5'd17: v = 28'sd128;
            5'd18: v = 28'sd64;
            5'd19: v = 28'sd32;
            5'd20: v = 28'sd16;
            5'd21: v = 28'sd8;
            5'd22: v = 28'sd4;
            5'd23: v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // clamp to the signed state range
    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (STATE_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi)
            return hi[STATE_W-1:0];
        else if (x < lo)
            return lo[STATE_W-1:0];
        return x[STATE_W-1:0];
    endfunction

    // Q8.24 to Q4.12 with floor and 16-bit saturation
    function automatic logic [15:0] to_q12(input logic signed [STATE_W-1:0] x);
        logic signed [STATE_W-1:0] v;
        v = x >>> 12;
        if (v > 32767)
            return 16'h7FFF;
        else if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

endpackage

FILE: hw/rtl/tilt_balance_cascade_controller_core.sv
// Top level of the tilt balance cascade controller: sequencer, CORDIC and
// one shared multiplier. Depends on tbc_pkg.
//
// Balance controller for a two-wheel robot. Each request on s_* is one
// sample: tuser 0 is an IMU sample (accel atan2 by CORDIC, complementary
// filter, lead/integral duty law, fault latch), tuser 1 an encoder sample
// (wheel angle average and second-order law giving the tilt reference).
// Every request gives exactly one result on m_*. The block works on one
// sample at a time: s_tready is low while it runs. An IMU sample passes
// these steps from one accept to the next: the idle state takes the
// request, CORDIC_STEPS iterations of the shift-add unit, 7
// multiplies on the shared 34x26 multiplier (each a multiply state and a
// write-back state), and the hand-off of the result to the output register.
// An IMU sample with both accel axes zero skips the CORDIC and goes, like
// an encoder sample (7 multiplies), straight to the multiplies. The hand-off
// cycle stretches only while an older result still waits on m_tready.
// The output register lets a new sample be taken while the last result
// still waits on m_tready.
// Configuration writes (cfg_*) are always ready and must come only while
// the block is idle. Unknown indexes are dropped.
module tilt_balance_cascade_controller_core
    import tbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_y[15:0], accel_z[31:16], gyro_rate[47:32], left_count[71:48],
    // right_count[95:72]
    input  logic [95:0] s_tdata,
    // cmd[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // duty[15:0], tilt_angle[31:16], tilt_reference[47:32], fault[48], zero pad
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    // configuration
    logic [15:0]        filter_gain_reg;
    logic [14:0]        inner_gain_reg;
    logic [14:0]        outer_gain_reg;
    logic [14:0]        tilt_limit_reg;
    logic signed [15:0] balance_offset_reg;
    logic [15:0]        reference_scale_reg;
    logic [23:0]        counts_to_rad_reg;

    // control
    state_t state_reg, state_next;
    op_t    op_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic cmd_reg;
    logic m_tvalid_reg;
    logic [55:0] m_tdata_reg;

    // captured sample
    logic signed [15:0] gyro_reg;
    logic signed [23:0] left_reg;
    logic signed [23:0] right_reg;

    // CORDIC
    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;

    // controller state, Q8.24
    logic signed [STATE_W-1:0] afo_reg, gfo_reg, gprev_reg, gint_reg, fused_reg;
    logic signed [STATE_W-1:0] duty_reg, eprev_reg, e_reg, phi_reg;
    logic signed [STATE_W-1:0] oo0_reg, oo1_reg, oi0_reg, oi1_reg, ref_reg;
    logic fault_reg;

    logic signed [63:0] acc_reg, acc2_reg;
    logic signed [P_W-1:0] prod_reg;

    logic s_accept, out_load, finish_op, both_zero;
    logic signed [63:0] a_wide;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  prod_next;
    logic signed [63:0] p16, p24, pfull, sum_lr;
    logic signed [XY_W-1:0] x_in, y_in, dx, dy;
    logic signed [63:0] limit;

    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_load  = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign finish_op = (op_reg == OP_DUTY) || (op_reg == OP_DRIVE);
    assign both_zero = (s_tdata[15:0] == 16'd0) && (s_tdata[31:16] == 16'd0);

    // atan2 arguments: x = accel_y, y = -accel_z, prescaled by 2^14
    assign x_in = XY_W'($signed(s_tdata[15:0])) <<< 14;
    assign y_in = -(XY_W'($signed(s_tdata[31:16])) <<< 14);
    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_accept)
                    state_next = (s_tuser == CMD_ENC || both_zero) ? ST_MUL : ST_CORDIC;
            ST_CORDIC:
                if (cnt_reg == CNT_W'(CORDIC_ITERS - 1))
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_WB;
            ST_WB:
                state_next = finish_op ? ST_FINISH : ST_MUL;
            ST_FINISH:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
    end

    // shared multiplier operand select
    always_comb
    begin
        a_wide = '0;
        mul_b  = '0;
        unique case (op_reg)
            OP_AFILT: begin
                a_wide = 64'(z_reg) - 64'(afo_reg);
                mul_b  = MB_W'({1'b0, filter_gain_reg});
            end
            OP_GYRO: begin
                a_wide = 64'(gyro_reg);
                mul_b  = K_GYRO;
            end
            OP_HPF: begin
                a_wide = 64'(gfo_reg) + 64'(gint_reg) - 64'(gprev_reg);
                mul_b  = MB_W'(17'h10000 - {1'b0, filter_gain_reg});
            end
            OP_REF: begin
                a_wide = 64'(ref_reg);
                mul_b  = MB_W'({1'b0, reference_scale_reg});
            end
            OP_LEAD: begin
                a_wide = 64'(e_reg);
                mul_b  = K_LEAD_NUM_NEG;
            end
            OP_LAG: begin
                a_wide = 64'(eprev_reg);
                mul_b  = K_LEAD_OLD;
            end
            OP_DUTY: begin
                a_wide = acc_reg;
                mul_b  = MB_W'({1'b0, inner_gain_reg, 4'd0});
            end
            OP_LEFT: begin
                a_wide = 64'(left_reg);
                mul_b  = MB_W'({1'b0, counts_to_rad_reg});
            end
            OP_RIGHT: begin
                a_wide = 64'(right_reg);
                mul_b  = MB_W'({1'b0, counts_to_rad_reg});
            end
            OP_PHI: begin
                a_wide = 64'(phi_reg);
                mul_b  = K_D2_B;
            end
            OP_PHI2: begin
                a_wide = 64'(oi1_reg);
                mul_b  = K_D2_B;
            end
            OP_A1: begin
                a_wide = 64'(oo0_reg);
                mul_b  = K_D2_A1;
            end
            OP_A2: begin
                a_wide = 64'(oo1_reg);
                mul_b  = K_D2_A2;
            end
            OP_DRIVE: begin
                a_wide = acc_reg;
                mul_b  = MB_W'({1'b0, outer_gain_reg, 4'd0});
            end
            default: begin
                a_wide = '0;
                mul_b  = '0;
            end
        endcase
        mul_a = a_wide[MA_W-1:0];
    end

    assign prod_next = mul_a * mul_b;
    assign pfull  = 64'(prod_reg);
    assign p16    = pfull >>> 16;
    assign p24    = pfull >>> 24;
    assign sum_lr = acc_reg + pfull;
    assign limit  = 64'($signed({1'b0, tilt_limit_reg})) <<< 12;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_gain_reg     <= 16'd383;
            inner_gain_reg      <= 15'd4096;
            outer_gain_reg      <= 15'd2458;
            tilt_limit_reg      <= 15'd4096;
            balance_offset_reg  <= 16'sd1024;
            reference_scale_reg <= 16'd44282;
            counts_to_rad_reg   <= 24'd49383;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FILTER_GAIN:     filter_gain_reg     <= cfg_data[15:0];
                CFG_INNER_GAIN:      inner_gain_reg      <= cfg_data[14:0];
                CFG_OUTER_GAIN:      outer_gain_reg      <= cfg_data[14:0];
                CFG_TILT_LIMIT:      tilt_limit_reg      <= cfg_data[14:0];
                CFG_BALANCE_OFFSET:  balance_offset_reg  <= $signed(cfg_data[15:0]);
                CFG_REFERENCE_SCALE: reference_scale_reg <= cfg_data[15:0];
                CFG_COUNTS_TO_RAD:   counts_to_rad_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_AFILT;
            cnt_reg      <= '0;
            cmd_reg      <= CMD_IMU;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_accept)
            begin
                cmd_reg <= s_tuser;
                op_reg  <= (s_tuser == CMD_ENC) ? OP_LEFT : OP_AFILT;
                cnt_reg <= '0;
            end
            else if (state_reg == ST_CORDIC)
                cnt_reg <= cnt_reg + 1'b1;
            else if (state_reg == ST_WB && !finish_op)
                op_reg <= op_t'(op_reg + 4'd1);
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            m_tdata_reg <= {7'd0, fault_reg, to_q12(ref_reg), to_q12(fused_reg),
                            (cmd_reg == CMD_ENC) ? 16'd0 : to_q12(duty_reg)};
    end

    // sample capture, CORDIC and product register
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            gyro_reg  <= $signed(s_tdata[47:32]);
            left_reg  <= $signed(s_tdata[71:48]);
            right_reg <= $signed(s_tdata[95:72]);
            // fold into the right half plane first; both axes zero lands in
            // the last arm and leaves the angle at zero
            if (x_in < 0 && y_in >= 0)
            begin
                x_reg <= y_in;
                y_reg <= -x_in;
                z_reg <= HALF_PI;
            end
            else if (x_in < 0)
            begin
                x_reg <= -y_in;
                y_reg <= x_in;
                z_reg <= -HALF_PI;
            end
            else
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
        end
        else if (state_reg == ST_CORDIC)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_lut(cnt_reg);
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_lut(cnt_reg);
            end
        end
        if (state_reg == ST_MUL)
            prod_reg <= prod_next;
    end

    // write-back of each multiply step into the controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            afo_reg   <= '0;
            gfo_reg   <= '0;
            gprev_reg <= '0;
            gint_reg  <= '0;
            fused_reg <= '0;
            duty_reg  <= '0;
            eprev_reg <= '0;
            e_reg     <= '0;
            phi_reg   <= '0;
            oo0_reg   <= '0;
            oo1_reg   <= '0;
            oi0_reg   <= '0;
            oi1_reg   <= '0;
            ref_reg   <= '0;
            fault_reg <= 1'b0;
            acc_reg   <= '0;
            acc2_reg  <= '0;
        end
        else if (state_reg == ST_MUL && op_reg == OP_REF)
        begin
            fused_reg <= sat_state(64'(afo_reg) + 64'(gfo_reg)
                                   + (64'(balance_offset_reg) <<< 12));
        end
        else if (state_reg == ST_WB)
        begin
            unique case (op_reg)
                OP_AFILT: afo_reg <= sat_state(64'(afo_reg) + p16);
                OP_GYRO:  gint_reg <= sat_state(64'(gint_reg) + p16);
                OP_HPF:
                begin
                    gfo_reg   <= sat_state(p16);
                    gprev_reg <= gint_reg;
                end
                OP_REF:
                begin
                    e_reg <= sat_state(p16 - 64'(fused_reg));
                    if (64'(fused_reg) > limit || 64'(fused_reg) < -limit)
                        fault_reg <= 1'b1;
                end
                OP_LEAD:  acc_reg <= p24;
                OP_LAG:   acc_reg <= acc_reg + p24;
                OP_DUTY:
                begin
                    duty_reg  <= sat_state(64'(duty_reg) + p16);
                    eprev_reg <= e_reg;
                end
                OP_LEFT:  acc_reg <= pfull;
                OP_RIGHT: phi_reg <= sat_state((sum_lr >>> 1) - 64'(fused_reg));
                OP_PHI:   acc_reg <= p24;
                OP_PHI2:  acc_reg <= acc_reg - p24;
                OP_A1:    acc2_reg <= p24;
                OP_A2:    acc2_reg <= acc2_reg - p24;
                OP_DRIVE:
                begin
                    ref_reg <= sat_state(acc2_reg + p16);
                    oo0_reg <= sat_state(acc2_reg + p16);
                    oo1_reg <= oo0_reg;
                    oi0_reg <= phi_reg;
                    oi1_reg <= oi0_reg;
                end
                default: ;
            endcase
        end
    end

    // checks
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input ready while busy");

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |=> fault_reg)
        else $error("fault latch cleared");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == ST_CORDIC || state_reg == ST_MUL))
        else $error("accepted request did not start work");

    a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORDIC) |-> (cnt_reg < CNT_W'(CORDIC_ITERS)))
        else $error("CORDIC ran past its step count");

endmodule

FILE: sim/tilt_balance_cascade_controller_core_tb.sv
// Self-checking testbench for tilt_balance_cascade_controller_core.
// Depends on tbc_pkg and the core RTL. A cycle-free predictor of the complementary
// filter and both control laws checks every result that leaves the block.
`timescale 1ns / 1ps

module tilt_balance_cascade_controller_core_tb;
    import tbc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // accel_y[15:0], accel_z[31:16], gyro_rate[47:32], left_count[71:48],
    // right_count[95:72]
    logic [95:0] s_tdata;
    // cmd[0]
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // duty[15:0], tilt_angle[31:16], tilt_reference[47:32], fault[48], zero pad
    logic [55:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    tilt_balance_cascade_controller_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    typedef struct packed {
        logic        fault;
        logic [15:0] reference;
        logic [15:0] tilt;
        logic [15:0] duty;
    } result_t;

    localparam longint GYRO_K   = 11993811;
    localparam longint LEAD_NUM = 17448305;
    localparam longint LEAD_OLD = 16106127;
    localparam longint D2_A1    = 20333986;
    localparam longint D2_A2    = 6001210;
    localparam longint D2_B     = 269442;
    localparam longint PI_HALF  = 26353589;

    // predictor configuration copy
    longint m_fgain, m_igain, m_ogain, m_limit, m_offset, m_rscale, m_c2r;
    // predictor state, Q8.24
    longint p_afilt, p_gfilt, p_gprev, p_gint, p_tilt, p_duty, p_eprev;
    longint p_rout1, p_rout2, p_phi1, p_phi2, p_ref;
    bit     p_fault;

    result_t expected_results[$];
    int      error_count;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // floor(a*b / 2^sh); 64-bit products are ample for the operand ranges here
    function automatic longint mul_floor(longint a, longint b, int sh);
        longint ah;
        longint al;
        ah = a >>> 16;
        al = a - ah * 65536;
        return (ah * b + ((al * b) >>> 16)) >>> (sh - 16);
    endfunction

    function automatic longint clamp_state(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic logic [15:0] port_q12(longint x);
        longint v;
        v = x >>> 12;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic longint accel_angle(longint x, longint y);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x * 16384;
        y = y * 16384;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = PI_HALF;
            end
            else
            begin
                t = x; x = -y; y = t; z = -PI_HALF;
            end
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += longint'(atan_lut(i[4:0]));
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(atan_lut(i[4:0]));
            end
        end
        return z;
    endfunction

    task automatic predictor_reset();
        m_fgain = 383; m_igain = 4096; m_ogain = 2458; m_limit = 4096;
        m_offset = 1024; m_rscale = 44282; m_c2r = 49383;
        p_afilt = 0; p_gfilt = 0; p_gprev = 0; p_gint = 0; p_tilt = 0;
        p_duty = 0; p_eprev = 0; p_rout1 = 0; p_rout2 = 0; p_phi1 = 0;
        p_phi2 = 0; p_ref = 0; p_fault = 1'b0;
    endtask

    // advance the predictor by one sample and queue its result
    task automatic predict_sample(logic cmd, logic [95:0] d);
        result_t r;
        longint  raw, e, inner, phi, drive, rr;
        r.duty = '0;
        if (cmd == CMD_IMU)
        begin
            raw = accel_angle(longint'($signed(d[15:0])), -longint'($signed(d[31:16])));
            p_afilt = clamp_state(p_afilt + mul_floor(raw - p_afilt, m_fgain, 16));
            p_gint = clamp_state(p_gint + mul_floor(longint'($signed(d[47:32])), GYRO_K, 16));
            p_gfilt = clamp_state(mul_floor(p_gfilt + p_gint - p_gprev, 65536 - m_fgain, 16));
            p_gprev = p_gint;
            p_tilt = clamp_state(p_afilt + p_gfilt + m_offset * 4096);
            e = clamp_state(mul_floor(p_ref, m_rscale, 16) - p_tilt);
            inner = mul_floor(e, -LEAD_NUM, 24) + mul_floor(p_eprev, LEAD_OLD, 24);
            p_duty = clamp_state(p_duty + mul_floor(inner, m_igain * 16, 16));
            p_eprev = e;
            if (p_tilt > m_limit * 4096 || p_tilt < -m_limit * 4096)
                p_fault = 1'b1;
            r.duty = port_q12(p_duty);
        end
        else
        begin
            // the wheel sum is halved and offset by the tilt before one clamp
            phi = clamp_state((((longint'($signed(d[71:48])) * m_c2r)
                  + (longint'($signed(d[95:72])) * m_c2r)) >>> 1) - p_tilt);
            drive = mul_floor(phi, D2_B, 24) - mul_floor(p_phi2, D2_B, 24);
            rr = clamp_state(mul_floor(p_rout1, D2_A1, 24) - mul_floor(p_rout2, D2_A2, 24)
                 + mul_floor(drive, m_ogain * 16, 16));
            p_rout2 = p_rout1;
            p_rout1 = rr;
            p_phi2 = p_phi1;
            p_phi1 = phi;
            p_ref = rr;
        end
        r.tilt = port_q12(p_tilt);
        r.reference = port_q12(p_ref);
        r.fault = p_fault;
        expected_results.push_back(r);
    endtask

    // one request on the sample stream, with a random lead-in gap; tvalid
    // stays up after the accept and is dropped by the next gap or drain
    task automatic send_sample(logic cmd, logic [15:0] ay, logic [15:0] az,
                               logic [15:0] gy, logic [23:0] lc, logic [23:0] rc);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {rc, lc, gy, az, ay};
        predict_sample(cmd, {rc, lc, gy, az, ay});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FILTER_GAIN:     m_fgain = value[15:0];
            CFG_INNER_GAIN:      m_igain = value[14:0];
            CFG_OUTER_GAIN:      m_ogain = value[14:0];
            CFG_TILT_LIMIT:      m_limit = value[14:0];
            CFG_BALANCE_OFFSET:  m_offset = longint'($signed(value[15:0]));
            CFG_REFERENCE_SCALE: m_rscale = value[15:0];
            CFG_COUNTS_TO_RAD:   m_c2r = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic random_sample(bit realistic);
        logic [15:0] ay, az, gy;
        logic [23:0] lc, rc;
        ay = $urandom; az = $urandom; gy = $urandom; lc = $urandom; rc = $urandom;
        if (realistic)
        begin
            // near-upright robot: small rates and modest wheel travel
            gy = $signed(16'($urandom_range(0, 400))) - 16'sd200;
            lc = $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
            rc = lc + 24'($urandom_range(0, 40)) - 24'd20;
            if ($urandom_range(0, 3) != 0)
                az = 16'($urandom_range(0, 2000)) - 16'd1000;
        end
        send_sample($urandom_range(0, 4) == 0, ay, az, gy, lc, rc);
    endtask

    task automatic test_directed();
        send_sample(CMD_IMU, 16'h0000, 16'h0000, 16'h0000, '0, '0);    // both accel zero
        send_sample(CMD_IMU, 16'h8000, 16'h0000, 16'h7FFF, '0, '0);    // angle +pi
        send_sample(CMD_IMU, 16'h7FFF, 16'h8000, 16'h8000, '1, '1);
        send_sample(CMD_IMU, 16'h8000, 16'h7FFF, 16'h7FFF, '0, '0);
        send_sample(CMD_IMU, 16'h8000, 16'h8000, 16'hFFFF, '0, '0);
        send_sample(CMD_IMU, 16'h0000, 16'h7FFF, 16'h0001, '0, '0);
        send_sample(CMD_ENC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_sample(CMD_ENC, '0, '0, '0, 24'h800000, 24'h800000);
        send_sample(CMD_ENC, '0, '0, '0, 24'h7FFFFF, 24'h800000);
        send_sample(CMD_ENC, '0, '0, '0, 24'h000001, 24'hFFFFFF);
        // hold gyro at full scale so the integrator ramps up
        repeat (12)
            send_sample(CMD_IMU, 16'h1000, 16'h1000, 16'h7FFF, '0, '0);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        write_register(CFG_FILTER_GAIN, 24'h00FFFF);
        write_register(CFG_INNER_GAIN, 24'h007FFF);
        write_register(CFG_OUTER_GAIN, 24'h007FFF);
        write_register(CFG_TILT_LIMIT, 24'h007FFF);
        write_register(CFG_BALANCE_OFFSET, 24'h008000);
        write_register(CFG_REFERENCE_SCALE, 24'h00FFFF);
        write_register(CFG_COUNTS_TO_RAD, 24'hFFFFFF);
        write_register(3'd7, 24'hABCDEF);                               // unknown index
        repeat (100) random_sample(1'b0);
        wait_drained();
        write_register(CFG_FILTER_GAIN, 24'h0);
        write_register(CFG_INNER_GAIN, 24'h0);
        write_register(CFG_OUTER_GAIN, 24'h0);
        write_register(CFG_TILT_LIMIT, 24'h0);
        write_register(CFG_BALANCE_OFFSET, 24'h007FFF);
        write_register(CFG_REFERENCE_SCALE, 24'h0);
        write_register(CFG_COUNTS_TO_RAD, 24'h0);
        repeat (80) random_sample(1'b0);
        wait_drained();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_register(CFG_FILTER_GAIN, 24'($urandom_range(0, 65535)));
            write_register(CFG_INNER_GAIN, 24'($urandom_range(0, 32767)));
            write_register(CFG_OUTER_GAIN, 24'($urandom_range(0, 32767)));
            write_register(CFG_TILT_LIMIT, 24'($urandom_range(0, 32767)));
            write_register(CFG_BALANCE_OFFSET, 24'($urandom_range(0, 65535)));
            write_register(CFG_REFERENCE_SCALE, 24'($urandom_range(0, 65535)));
            write_register(CFG_COUNTS_TO_RAD, 24'($urandom));
            repeat (175) random_sample($urandom_range(0, 3) != 0);
            wait_drained();
        end
    endtask

    // result side: random stalls, compare against the oldest prediction
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[48:0];
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.duty !== want.duty)
                begin
                    $display("%0t: duty expected %h actual %h", $time, want.duty, got.duty);
                    error_count++;
                end
                if (got.tilt !== want.tilt)
                begin
                    $display("%0t: tilt expected %h actual %h", $time, want.tilt, got.tilt);
                    error_count++;
                end
                if (got.reference !== want.reference)
                begin
                    $display("%0t: reference expected %h actual %h", $time,
                             want.reference, got.reference);
                    error_count++;
                end
                if (got.fault !== want.fault)
                begin
                    $display("%0t: fault expected %b actual %b", $time, want.fault, got.fault);
                    error_count++;
                end
            end
        end
    end

    // after each accepted result, hold ready low for a random stall, or not at all
    int stall_left;
    int stall_draw;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            stall_draw = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            if (stall_draw != 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= stall_draw - 1;
            end
        end
        else if (!m_tready)
        begin
            if (stall_left == 0)
                m_tready <= 1'b1;
            else
                stall_left <= stall_left - 1;
        end
    end

    initial
    begin
        error_count = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        predictor_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_random_phases();
        wait_drained();
        if (error_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // slowest run: ~1300 samples, each with its lead-in gap, busy time and result stall, plus drains
    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
